// ----- design/rnsc_pkg.sv -----
// Package for the real number string checker: character codes, scan phase
// type and the per-string scan state record.
// No dependencies; used by real_number_string_checker.
package rnsc_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;

    typedef enum logic [1:0] {
        PH_START      = 2'd0,
        PH_MANTISSA   = 2'd1,
        PH_EXP_MARK   = 2'd2,
        PH_EXP_DIGITS = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   minus_seen;
        logic   point_seen;
        logic   exponent_seen;
        logic   exponent_sign_seen;
        logic   ends_on_digit;
        logic   rejected;
        logic   trailing_space;
        logic   terminated;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        phase:              PH_START,
        minus_seen:         1'b0,
        point_seen:         1'b0,
        exponent_seen:      1'b0,
        exponent_sign_seen: 1'b0,
        ends_on_digit:      1'b0,
        rejected:           1'b0,
        trailing_space:     1'b0,
        terminated:         1'b0
    };

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- design/real_number_string_checker.sv -----
// Real number string checker: one character per request, verdict on the last one.
// The verdict is registered and appears on the master side in the cycle after
// the request that carries tlast is accepted. Throughput: one character per
// cycle, set only by the update of the scan flags; a verdict that waits on a
// stalled master side holds the input until it is taken. Synchronous active-low
// reset clears the scan state and the output valid; depends on rnsc_pkg.
module real_number_string_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,   // last character of the string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] is_number, [7:1] zero
);

    // Scan state for the string in progress. It is cleared after each string,
    // so a verdict depends only on the characters since the previous tlast.
    rnsc_pkg::scan_state_t state_reg, state_next;
    rnsc_pkg::scan_state_t scan_work;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg,  m_tdata_next;

    logic s_acc;
    logic verdict_ok;

    // A character may enter whenever the output register is empty or is being
    // emptied in this cycle; only a pending, stalled verdict holds the input.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // Character update. A character that is not a space or NUL is classified
    // according to the current phase. In the mantissa, anything other than a
    // digit or the first point drops back to the start rules and is looked at
    // again there, which is how a minus after digits is still accepted.
    always_comb begin
        logic [7:0] c;
        logic       digit;
        logic       handled;
        c         = s_tdata;
        digit     = rnsc_pkg::is_digit(c);
        handled   = 1'b0;
        scan_work = state_reg;
        if (s_tuser[0] && !state_reg.terminated && !state_reg.rejected) begin
            if (c == rnsc_pkg::CH_NUL) begin
                scan_work.terminated = 1'b1;
            end else if (c == rnsc_pkg::CH_SPACE) begin
                scan_work.trailing_space = 1'b1;
            end else begin
                scan_work.trailing_space = 1'b0;
                if (state_reg.phase == rnsc_pkg::PH_MANTISSA) begin
                    if (digit) begin
                        scan_work.ends_on_digit = 1'b1;
                        handled = 1'b1;
                    end else if (c == rnsc_pkg::CH_POINT && !state_reg.point_seen) begin
                        scan_work.point_seen    = 1'b1;
                        scan_work.ends_on_digit = 1'b1;
                        handled = 1'b1;
                    end else begin
                        scan_work.phase = rnsc_pkg::PH_START;
                    end
                end
                if (!handled) begin
                    case (scan_work.phase)
                        rnsc_pkg::PH_START: begin
                            if (c == rnsc_pkg::CH_MINUS && !scan_work.minus_seen) begin
                                scan_work.minus_seen    = 1'b1;
                                scan_work.phase         = rnsc_pkg::PH_MANTISSA;
                                scan_work.ends_on_digit = 1'b0;
                            end else if (c == rnsc_pkg::CH_POINT && !scan_work.point_seen
                                         && scan_work.ends_on_digit) begin
                                scan_work.point_seen    = 1'b1;
                                scan_work.phase         = rnsc_pkg::PH_MANTISSA;
                                scan_work.ends_on_digit = 1'b0;
                            end else if ((c == rnsc_pkg::CH_LOW_E || c == rnsc_pkg::CH_UP_E)
                                         && !scan_work.exponent_seen
                                         && scan_work.ends_on_digit) begin
                                scan_work.exponent_seen = 1'b1;
                                scan_work.phase         = rnsc_pkg::PH_EXP_MARK;
                                scan_work.ends_on_digit = 1'b0;
                            end else if (digit) begin
                                scan_work.phase         = rnsc_pkg::PH_MANTISSA;
                                scan_work.ends_on_digit = 1'b1;
                            end else begin
                                scan_work.rejected = 1'b1;
                            end
                        end
                        rnsc_pkg::PH_EXP_MARK: begin
                            // One optional sign straight after the exponent mark.
                            scan_work.phase = rnsc_pkg::PH_EXP_DIGITS;
                            if ((c == rnsc_pkg::CH_MINUS || c == rnsc_pkg::CH_PLUS)
                                && !scan_work.exponent_sign_seen) begin
                                scan_work.exponent_sign_seen = 1'b1;
                                scan_work.ends_on_digit      = 1'b0;
                            end else if (digit) begin
                                scan_work.ends_on_digit = 1'b1;
                            end else begin
                                scan_work.rejected = 1'b1;
                            end
                        end
                        default: begin
                            // Exponent digits: only digits may follow.
                            if (digit) begin
                                scan_work.ends_on_digit = 1'b1;
                            end else begin
                                scan_work.rejected = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // The verdict looks at the state including the last character. Trailing
    // spaces are tolerated only while still in the mantissa.
    assign verdict_ok = !scan_work.rejected && scan_work.ends_on_digit
                        && !(scan_work.trailing_space
                             && (scan_work.phase == rnsc_pkg::PH_EXP_MARK
                                 || scan_work.phase == rnsc_pkg::PH_EXP_DIGITS));

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_acc) begin
            state_next = s_tlast ? rnsc_pkg::SCAN_CLEAR : scan_work;
            if (s_tlast) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {7'b0, verdict_ok};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rnsc_pkg::SCAN_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // The verdict byte is payload only and needs no reset.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // Every string starts from a clean scan state.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (state_reg == rnsc_pkg::SCAN_CLEAR))
        else $error("scan state not cleared after the last character");

    // A verdict only appears as the result of an accepted last character.
    a_verdict_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_acc && s_tlast))
        else $error("verdict raised without a last character");

    // Once a string is rejected it stays rejected until its end.
    a_reject_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.rejected && !(s_acc && s_tlast)) |=> state_reg.rejected)
        else $error("rejection lost before the end of the string");

    // A rejected string never yields a positive verdict.
    a_reject_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast && state_reg.rejected) |=> (m_tvalid && !m_tdata[0]))
        else $error("rejected string reported as a number");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for real_number_string_checker: strings are sent one
// character per request, each verdict compared with an in-bench scanner or a
// typed-in value. Depends on rnsc_pkg and checker RTL; needs no files or args.
`timescale 1ns / 100ps

module tb_top;

    // Where the expected verdict of a directed row comes from.
    typedef enum logic [1:0] {
        WANT_NO,
        WANT_YES,
        WANT_MODEL
    } verdict_src_t;

    typedef struct packed {
        logic [7:0]   code;
        logic         has_char;
        logic         last;
        verdict_src_t want;
    } directed_row_t;

    localparam int RANDOM_ITEMS = 800;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic [0:0] s_tuser  = 1'b0;    // [0] has_char
    logic       s_tlast  = 1'b0;    // last character of the string
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] is_number, [7:1] zero

    // The bench's own copy of the scan state, and the verdicts still owed.
    rnsc_pkg::scan_state_t scan = rnsc_pkg::SCAN_CLEAR;
    logic        expected_verdicts [$];
    logic [7:0]  text_q [$];

    bit gaps_on = 1'b1;
    int errors = 0;
    int strings_sent = 0;
    int numbers_expected = 0;
    int verdicts_seen = 0;
    int items_sent = 0;

    // Directed strings: empty, a single digit, an ignored empty request, a
    // minus after digits, an upper-case exponent with sign, trailing spaces
    // after exponent digits and after a point, a NUL terminator followed by a
    // top-bit byte, a lone top-bit byte and an early rejection.
    directed_row_t directed_rows [24] = '{
        '{rnsc_pkg::CH_NUL,          1'b0, 1'b1, WANT_NO},
        '{rnsc_pkg::CH_ZERO + 8'd9,  1'b1, 1'b1, WANT_YES},
        '{8'hA5,                     1'b0, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO,         1'b1, 1'b1, WANT_YES},
        '{rnsc_pkg::CH_ZERO + 8'd1,  1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_MINUS,        1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd2,  1'b1, 1'b1, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd5,  1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_UP_E,         1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_MINUS,        1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd7,  1'b1, 1'b1, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd3,  1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_LOW_E,        1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd5,  1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_SPACE,        1'b1, 1'b1, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd7,  1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_POINT,        1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_SPACE,        1'b1, 1'b1, WANT_MODEL},
        '{rnsc_pkg::CH_ZERO + 8'd1,  1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_NUL,          1'b1, 1'b0, WANT_MODEL},
        '{8'hFF,                     1'b1, 1'b1, WANT_MODEL},
        '{8'hFF,                     1'b1, 1'b1, WANT_NO},
        '{rnsc_pkg::CH_PLUS,         1'b1, 1'b0, WANT_MODEL},
        '{rnsc_pkg::CH_POINT,        1'b1, 1'b1, WANT_NO}
    };

    real_number_string_checker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Generous ceiling on the length of the whole run.
    initial begin
        #(200_000 * 12);
        $display("Timeout at %0t with %0d verdicts outstanding.", $time,
                 expected_verdicts.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] rand_digit();
        return rnsc_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Mostly the characters the scanner treats specially, sometimes any byte.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0: return rnsc_pkg::CH_MINUS;
            1: return rnsc_pkg::CH_POINT;
            2: return rnsc_pkg::CH_PLUS;
            3: return rnsc_pkg::CH_LOW_E;
            4: return rnsc_pkg::CH_UP_E;
            5: return rnsc_pkg::CH_SPACE;
            6: return rnsc_pkg::CH_NUL;
            7: return 8'($urandom);
            default: return rand_digit();
        endcase
    endfunction

    // One significant character, neither a space nor NUL. In the mantissa a
    // character that does not extend it is looked at again from the start
    // phase, which is how a lone minus after digits gets accepted.
    function automatic void scan_symbol(input logic [7:0] c);
        logic digit;
        digit = (c >= rnsc_pkg::CH_ZERO) && (c <= rnsc_pkg::CH_NINE);
        scan.trailing_space = 1'b0;
        if (scan.phase == rnsc_pkg::PH_MANTISSA) begin
            if (digit) begin
                scan.ends_on_digit = 1'b1;
                return;
            end
            if (c == rnsc_pkg::CH_POINT && !scan.point_seen) begin
                scan.point_seen    = 1'b1;
                scan.ends_on_digit = 1'b1;
                return;
            end
            scan.phase = rnsc_pkg::PH_START;
        end
        if (scan.phase == rnsc_pkg::PH_START) begin
            if (c == rnsc_pkg::CH_MINUS && !scan.minus_seen) begin
                scan.minus_seen    = 1'b1;
                scan.phase         = rnsc_pkg::PH_MANTISSA;
                scan.ends_on_digit = 1'b0;
            end else if (c == rnsc_pkg::CH_POINT && !scan.point_seen
                         && scan.ends_on_digit) begin
                scan.point_seen    = 1'b1;
                scan.phase         = rnsc_pkg::PH_MANTISSA;
                scan.ends_on_digit = 1'b0;
            end else if ((c == rnsc_pkg::CH_LOW_E || c == rnsc_pkg::CH_UP_E)
                         && !scan.exponent_seen && scan.ends_on_digit) begin
                scan.exponent_seen = 1'b1;
                scan.phase         = rnsc_pkg::PH_EXP_MARK;
                scan.ends_on_digit = 1'b0;
            end else if (digit) begin
                scan.phase         = rnsc_pkg::PH_MANTISSA;
                scan.ends_on_digit = 1'b1;
            end else begin
                scan.rejected = 1'b1;
            end
        end else if (scan.phase == rnsc_pkg::PH_EXP_MARK) begin
            scan.phase = rnsc_pkg::PH_EXP_DIGITS;
            if ((c == rnsc_pkg::CH_MINUS || c == rnsc_pkg::CH_PLUS)
                && !scan.exponent_sign_seen) begin
                scan.exponent_sign_seen = 1'b1;
                scan.ends_on_digit      = 1'b0;
            end else if (digit) begin
                scan.ends_on_digit = 1'b1;
            end else begin
                scan.rejected = 1'b1;
            end
        end else begin
            if (digit)
                scan.ends_on_digit = 1'b1;
            else
                scan.rejected = 1'b1;
        end
    endfunction

    // Advances the scan by one accepted request and, on the last one, queues
    // the verdict: the typed-in one for a directed row, else the scanner's.
    function automatic void scan_request(input logic [7:0] code, input logic has_char,
                                         input logic last, input verdict_src_t want);
        logic verdict;
        if (has_char && !scan.terminated && !scan.rejected) begin
            if (code == rnsc_pkg::CH_NUL)
                scan.terminated = 1'b1;
            else if (code == rnsc_pkg::CH_SPACE)
                scan.trailing_space = 1'b1;
            else
                scan_symbol(code);
        end
        if (last) begin
            verdict = !scan.rejected && scan.ends_on_digit
                      && !(scan.trailing_space && scan.phase >= rnsc_pkg::PH_EXP_MARK);
            if (want != WANT_MODEL)
                verdict = (want == WANT_YES);
            expected_verdicts.push_back(verdict);
            strings_sent++;
            if (verdict)
                numbers_expected++;
            scan = rnsc_pkg::SCAN_CLEAR;
        end
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, so that valid is driven once per time step.
    task automatic send_request(input logic [7:0] code, input logic has_char,
                                input logic last, input verdict_src_t want);
        while (gaps_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= has_char;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        scan_request(code, has_char, last, want);
        @(negedge aclk);
    endtask

    // The receiver stalls at random as well, except during the quiet stretch.
    always @(negedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin : check_verdict
        logic want;
        if (aresetn && m_tvalid && m_tready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict %0d arrived with none expected", $time, m_tdata[0]);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want) begin
                    $display("%0t: is_number expected %0d, actual %0d", $time, want,
                             m_tdata[0]);
                    errors++;
                end
                if (m_tdata[7:1] !== 7'd0) begin
                    $display("%0t: padding expected 0, actual %h", $time, m_tdata[7:1]);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int  style;
        int  pos;
        bit  empty_end;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].code, directed_rows[i].has_char,
                         directed_rows[i].last, directed_rows[i].want);

        while (items_sent < RANDOM_ITEMS) begin
            // A quiet stretch in the middle, with neither side idling.
            gaps_on = !(items_sent >= 300 && items_sent < 450);
            text_q.delete();
            style = $urandom_range(99);
            if (style < 75) begin
                // A well-formed number with random content; some get broken below.
                repeat ($urandom_range(1)) text_q.push_back(rnsc_pkg::CH_SPACE);
                if ($urandom_range(2) == 0)
                    text_q.push_back(rnsc_pkg::CH_MINUS);
                repeat ($urandom_range(1, 4)) text_q.push_back(rand_digit());
                if ($urandom_range(1) == 1) begin
                    text_q.push_back(rnsc_pkg::CH_POINT);
                    repeat ($urandom_range(3)) text_q.push_back(rand_digit());
                end
                if ($urandom_range(2) == 0) begin
                    text_q.push_back($urandom_range(1) ? rnsc_pkg::CH_LOW_E
                                                       : rnsc_pkg::CH_UP_E);
                    if ($urandom_range(1) == 1)
                        text_q.push_back($urandom_range(1) ? rnsc_pkg::CH_PLUS
                                                           : rnsc_pkg::CH_MINUS);
                    repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
                end
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 2)) text_q.push_back(rnsc_pkg::CH_SPACE);
                if (style >= 55) begin
                    pos = $urandom_range(text_q.size() - 1);
                    case ($urandom_range(2))
                        0: text_q[pos] = pick_char();
                        1: text_q.insert(pos, pick_char());
                        default: if (text_q.size() > 1) text_q.delete(pos);
                    endcase
                end
            end else begin
                // Noise: a short run of arbitrary characters, possibly none.
                repeat ($urandom_range(6)) text_q.push_back(pick_char());
            end

            empty_end = (text_q.size() == 0) || ($urandom_range(5) == 0);
            foreach (text_q[i]) begin
                if ($urandom_range(99) < 3)
                    send_request(8'($urandom), 1'b0, 1'b0, WANT_MODEL);
                send_request(text_q[i], 1'b1, !empty_end && (i == text_q.size() - 1),
                             WANT_MODEL);
                items_sent++;
            end
            if (empty_end) begin
                send_request(8'($urandom), 1'b0, 1'b1, WANT_MODEL);
                items_sent++;
            end
        end

        gaps_on = 1'b1;
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Scanned %0d strings in %0d random character requests after the directed set;",
                 strings_sent, items_sent);
        $display("%0d verdicts came back, %0d of the strings were valid numbers.",
                 verdicts_seen, numbers_expected);
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rnsc_pkg.sv
design/real_number_string_checker.sv
verif/tb_top.sv
